// File: hdl/turtle_path_interpreter_defines.svh
// Assertion macros shared by the checker file.
`ifndef TURTLE_PATH_INTERPRETER_DEFINES_SVH
`define TURTLE_PATH_INTERPRETER_DEFINES_SVH

// same-cycle implication, reset masked
`define TPI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define TPI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tpi_pkg.sv
// Types, constants and codes of the turtle path interpreter.
package tpi_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_ANGLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_ANGLE = 3'd6;

    localparam logic signed [23:0] START_X_RST  = 24'sd102400;
    localparam logic signed [23:0] START_Y_RST  = 24'sd179200;
    localparam logic signed [15:0] START_DX_RST = 16'sd0;
    localparam logic signed [15:0] START_DY_RST = -16'sd16384;
    localparam logic        [15:0] STEP_LEN_RST = 16'd1280;
    localparam logic signed [15:0] COS_RST      = 16'sd14195;
    localparam logic signed [15:0] SIN_RST      = 16'sd8185;

    localparam logic [7:0] SYM_FWD  = 8'h46;
    localparam logic [7:0] SYM_CW   = 8'h2B;
    localparam logic [7:0] SYM_CCW  = 8'h2D;
    localparam logic [7:0] SYM_PUSH = 8'h5B;
    localparam logic [7:0] SYM_POP  = 8'h5D;

    localparam logic [1:0] ST_SEGMENT   = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FWD,
        OP_CW,
        OP_CCW,
        OP_PUSH,
        OP_POP
    } t_op;

    typedef struct packed {
        logic [7:0] symbol;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] seg_start_x;
        logic signed [23:0] seg_start_y;
        logic signed [23:0] seg_end_x;
        logic signed [23:0] seg_end_y;
        logic        [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
    } t_pose;

endpackage

// File: hdl/tpi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: hdl/tpi_alu.sv
// Pose arithmetic: forward step and rotation, rounded and saturated.
module tpi_alu (
    input  tpi_pkg::t_op        i_op,
    input  tpi_pkg::t_pose      i_pose,
    input  logic        [15:0]  i_step_len,
    input  logic signed [15:0]  i_cos,
    input  logic signed [15:0]  i_sin,
    output tpi_pkg::t_pose      o_pose
);
    import tpi_pkg::*;

    logic signed [32:0] prod_x, prod_y;
    logic signed [18:0] dx, dy;
    logic signed [24:0] sum_x, sum_y;
    logic signed [31:0] xc, ys, yc, xs;
    logic signed [33:0] rot_x, rot_y;
    logic signed [19:0] rnd_x, rnd_y;

    function automatic logic signed [23:0] sat_pos(input logic signed [24:0] v);
        if (v > 25'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -25'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    function automatic logic signed [15:0] sat_dir(input logic signed [19:0] v);
        if (v > 20'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -20'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    always_comb begin
        prod_x = 33'(i_pose.dir_x) * $signed({17'd0, i_step_len});
        prod_y = 33'(i_pose.dir_y) * $signed({17'd0, i_step_len});
        dx     = 19'((prod_x + 33'sd8192) >>> 14);
        dy     = 19'((prod_y + 33'sd8192) >>> 14);
        sum_x  = 25'(i_pose.pos_x) + 25'(dx);
        sum_y  = 25'(i_pose.pos_y) + 25'(dy);

        xc = 32'(i_pose.dir_x) * 32'(i_cos);
        ys = 32'(i_pose.dir_y) * 32'(i_sin);
        yc = 32'(i_pose.dir_y) * 32'(i_cos);
        xs = 32'(i_pose.dir_x) * 32'(i_sin);

        if (i_op == OP_CW) begin
            rot_x = 34'(xc) + 34'(ys);
            rot_y = 34'(yc) - 34'(xs);
        end else begin
            rot_x = 34'(xc) - 34'(ys);
            rot_y = 34'(yc) + 34'(xs);
        end
        rnd_x = 20'((rot_x + 34'sd8192) >>> 14);
        rnd_y = 20'((rot_y + 34'sd8192) >>> 14);

        o_pose = i_pose;
        case (i_op)
            OP_FWD: begin
                o_pose.pos_x = sat_pos(sum_x);
                o_pose.pos_y = sat_pos(sum_y);
            end
            OP_CW, OP_CCW: begin
                o_pose.dir_x = sat_dir(rnd_x);
                o_pose.dir_y = sat_dir(rnd_y);
            end
            default: begin
                o_pose = i_pose;
            end
        endcase
    end
endmodule

// File: hdl/tpi_out_buf.sv
// Two-slot result buffer: output register plus skid register.
module tpi_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  tpi_pkg::t_out_item i_data,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output tpi_pkg::t_out_item o_data
);
    import tpi_pkg::*;

    logic      r_main_v, r_skid_v;
    t_out_item r_main, r_skid;
    logic      take;

    assign take    = r_main_v & i_ready;
    assign o_ready = ~r_skid_v;
    assign o_valid = r_main_v;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_main   <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_main_v || take) begin
                r_main   <= i_data;
                r_main_v <= 1'b1;
            end else begin
                r_skid   <= i_data;
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_main_v <= 1'b0;
        end
    end
endmodule

// File: hdl/turtle_path_interpreter.sv
// Top level of the turtle path interpreter.
// One symbol is taken per clock cycle, back to back, while the result buffer has room;
// each result is registered in the result buffer. The pose lives in registers; saved
// poses live in a STACK_DEPTH-entry RAM with registered read. A pop issues the read and
// the following symbol takes its pose straight from the read data, so a pop followed
// by any symbol still runs at one symbol per cycle. Results pass through a two-slot
// buffer; input ready drops only while both slots are held by a stalled output. No
// clearing pass is needed after reset. Start pose writes affect the pose only at the
// next restart; step length, cosine and sine writes apply from the next symbol on.
module turtle_path_interpreter #(
    parameter int STACK_DEPTH = tpi_pkg::STACK_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  tpi_pkg::t_in_item                  i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output tpi_pkg::t_out_item                 o_out,
    input  logic                               i_cfg_we,
    input  logic [tpi_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tpi_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tpi_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int PW = $bits(t_pose);

    logic signed [23:0] r_start_x, r_start_y;
    logic signed [15:0] r_start_dx, r_start_dy, r_cos, r_sin;
    logic        [15:0] r_step_len;

    t_pose         r_pose, eff_pose, alu_pose;
    logic          r_pop_pend;
    logic [CW-1:0] r_count, cnt_eff, cnt_m1, n_count;
    logic [PW-1:0] ram_rdata;
    logic          accept, push_ok, pop_ok, ram_we, ram_re, res_valid, buf_ready;
    t_op           op;
    t_out_item     res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x  <= START_X_RST;
            r_start_y  <= START_Y_RST;
            r_start_dx <= START_DX_RST;
            r_start_dy <= START_DY_RST;
            r_step_len <= STEP_LEN_RST;
            r_cos      <= COS_RST;
            r_sin      <= SIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_X:   r_start_x  <= i_cfg_data;
                CFG_START_Y:   r_start_y  <= i_cfg_data;
                CFG_START_DX:  r_start_dx <= i_cfg_data[15:0];
                CFG_START_DY:  r_start_dy <= i_cfg_data[15:0];
                CFG_STEP_LEN:  r_step_len <= i_cfg_data[15:0];
                CFG_COS_ANGLE: r_cos      <= i_cfg_data[15:0];
                CFG_SIN_ANGLE: r_sin      <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (i_in.symbol)
            SYM_FWD:  op = OP_FWD;
            SYM_CW:   op = OP_CW;
            SYM_CCW:  op = OP_CCW;
            SYM_PUSH: op = OP_PUSH;
            SYM_POP:  op = OP_POP;
            default:  op = OP_NONE;
        endcase
    end

    // popped pose forwarded from RAM read data; restart overrides all
    always_comb begin
        eff_pose = r_pose;
        if (r_pop_pend) begin
            eff_pose = t_pose'(ram_rdata);
        end
        cnt_eff = r_count;
        if (i_in.restart) begin
            eff_pose = '{pos_x: r_start_x, pos_y: r_start_y,
                         dir_x: r_start_dx, dir_y: r_start_dy};
            cnt_eff  = '0;
        end
    end

    assign accept  = i_in_valid & o_in_ready;
    assign push_ok = cnt_eff < CW'(STACK_DEPTH);
    assign pop_ok  = cnt_eff != '0;
    assign cnt_m1  = cnt_eff - CW'(1);
    assign ram_we  = accept & (op == OP_PUSH) & push_ok;
    assign ram_re  = accept & (op == OP_POP) & pop_ok;
    assign o_in_ready = buf_ready;

    always_comb begin
        n_count = cnt_eff;
        if (ram_we) begin
            n_count = cnt_eff + CW'(1);
        end else if (ram_re) begin
            n_count = cnt_m1;
        end
    end

    tpi_ram #(
        .WIDTH (PW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (cnt_eff[AW-1:0]),
        .i_wr_data (PW'(eff_pose)),
        .i_rd_en   (ram_re),
        .i_rd_addr (cnt_m1[AW-1:0]),
        .o_rd_data (ram_rdata)
    );

    tpi_alu u_alu (
        .i_op       (op),
        .i_pose     (eff_pose),
        .i_step_len (r_step_len),
        .i_cos      (r_cos),
        .i_sin      (r_sin),
        .o_pose     (alu_pose)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose     <= '{pos_x: START_X_RST, pos_y: START_Y_RST,
                            dir_x: START_DX_RST, dir_y: START_DY_RST};
            r_count    <= '0;
            r_pop_pend <= 1'b0;
        end else if (accept) begin
            r_pose     <= alu_pose;
            r_count    <= n_count;
            r_pop_pend <= ram_re;
        end else if (r_pop_pend) begin
            r_pose     <= t_pose'(ram_rdata);
            r_pop_pend <= 1'b0;
        end
    end

    always_comb begin
        res.seg_start_x = eff_pose.pos_x;
        res.seg_start_y = eff_pose.pos_y;
        res.seg_end_x   = eff_pose.pos_x;
        res.seg_end_y   = eff_pose.pos_y;
        res.status      = ST_SEGMENT;
        res_valid       = 1'b0;
        case (op)
            OP_FWD: begin
                res.seg_end_x = alu_pose.pos_x;
                res.seg_end_y = alu_pose.pos_y;
                res_valid     = accept;
            end
            OP_PUSH: begin
                res.status = ST_OVERFLOW;
                res_valid  = accept & ~push_ok;
            end
            OP_POP: begin
                res.status = ST_UNDERFLOW;
                res_valid  = accept & ~pop_ok;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    tpi_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (res),
        .o_ready (buf_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out)
    );
endmodule

// File: hdl/tpi_checker.sv
// Port-level checker for the turtle path interpreter, with its bind.
`include "turtle_path_interpreter_defines.svh"

module tpi_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input tpi_pkg::t_in_item              i_in,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input tpi_pkg::t_out_item             o_out
);
    import tpi_pkg::*;

    // error results carry the current position at both ends
    `TPI_ASSERT_NOW(a_err_point, o_out_valid && o_out.status != ST_SEGMENT, o_out.seg_start_x == o_out.seg_end_x && o_out.seg_start_y == o_out.seg_end_y && (o_out.status == ST_OVERFLOW || o_out.status == ST_UNDERFLOW), "error result is not a point")

    // a stalled result holds
    `TPI_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "stalled result changed")

    // input back-pressure only follows an output stall
    `TPI_ASSERT_NOW(a_ready_fall, $fell(o_in_ready), $past(o_out_valid && !i_out_ready), "input ready dropped without output stall")

    // restart then pop underflows, checked while the output is not stalled
    `TPI_ASSERT_NEXT(a_restart_pop, i_in_valid && o_in_ready && i_in.restart && i_in.symbol == SYM_POP && (!o_out_valid || i_out_ready), o_out_valid && o_out.status == ST_UNDERFLOW, "pop after restart did not underflow")
endmodule

bind turtle_path_interpreter tpi_checker u_tpi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

// File: test/tb_turtle_path_interpreter.sv
// Self-checking testbench for the turtle path interpreter: predicted segments against DUT results.
`timescale 1ns / 100ps

module tb_turtle_path_interpreter;
    import tpi_pkg::*;

    localparam int  DEPTH        = STACK_DEPTH_DEF;
    localparam int  DRAIN_CYCLES = 8;
    localparam int  HOLD_CYCLES  = 300;
    localparam longint POS_MAX   = 64'sd8388607;
    localparam longint POS_MIN   = -64'sd8388608;
    localparam longint DIR_MAX   = 64'sd32767;
    localparam longint DIR_MIN   = -64'sd32768;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    t_in_item               i_in = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out_item              o_out;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // turtle state and register mirror
    logic signed [23:0] cfg_start_x = START_X_RST;
    logic signed [23:0] cfg_start_y = START_Y_RST;
    logic signed [15:0] cfg_dir_x   = START_DX_RST;
    logic signed [15:0] cfg_dir_y   = START_DY_RST;
    logic        [15:0] cfg_step    = STEP_LEN_RST;
    logic signed [15:0] cfg_cos     = COS_RST;
    logic signed [15:0] cfg_sin     = SIN_RST;
    t_pose              pose;
    t_pose              saved_poses [DEPTH];
    int unsigned        saved_cnt = 0;
    t_out_item          pending_segs [$];

    int  mismatches   = 0;
    int  in_idle_pct  = 35;
    int  out_idle_pct = 35;
    bit  hold_req     = 1'b0;
    int  hold_left    = 0;

    turtle_path_interpreter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_op decode_symbol(logic [7:0] sym);
        case (sym)
            SYM_FWD:  return OP_FWD;
            SYM_CW:   return OP_CW;
            SYM_CCW:  return OP_CCW;
            SYM_PUSH: return OP_PUSH;
            SYM_POP:  return OP_POP;
            default:  return OP_NONE;
        endcase
    endfunction

    // round half up, then floor shift
    function automatic longint round_q14(longint v);
        return (v + 64'sd8192) >>> 14;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void load_start_pose();
        pose.pos_x = cfg_start_x;
        pose.pos_y = cfg_start_y;
        pose.dir_x = cfg_dir_x;
        pose.dir_y = cfg_dir_y;
        saved_cnt  = 0;
    endfunction

    function automatic void push_status(logic [1:0] st);
        t_out_item seg;
        seg.seg_start_x = pose.pos_x;
        seg.seg_start_y = pose.pos_y;
        seg.seg_end_x   = pose.pos_x;
        seg.seg_end_y   = pose.pos_y;
        seg.status      = st;
        pending_segs = {pending_segs, seg};
    endfunction

    function automatic void predict_turtle(t_in_item req);
        longint    px, py, dx, dy, c, s, len, nx, ny;
        t_out_item seg;
        if (req.restart)
            load_start_pose();
        px  = pose.pos_x;
        py  = pose.pos_y;
        dx  = pose.dir_x;
        dy  = pose.dir_y;
        c   = cfg_cos;
        s   = cfg_sin;
        len = cfg_step;
        case (decode_symbol(req.symbol))
            OP_FWD: begin
                nx = clamp(px + round_q14(dx * len), POS_MIN, POS_MAX);
                ny = clamp(py + round_q14(dy * len), POS_MIN, POS_MAX);
                seg.seg_start_x = pose.pos_x;
                seg.seg_start_y = pose.pos_y;
                seg.seg_end_x   = nx[23:0];
                seg.seg_end_y   = ny[23:0];
                seg.status      = ST_SEGMENT;
                pending_segs = {pending_segs, seg};
                pose.pos_x = nx[23:0];
                pose.pos_y = ny[23:0];
            end
            OP_CW: begin
                nx = clamp(round_q14(dx * c + dy * s), DIR_MIN, DIR_MAX);
                ny = clamp(round_q14(dy * c - dx * s), DIR_MIN, DIR_MAX);
                pose.dir_x = nx[15:0];
                pose.dir_y = ny[15:0];
            end
            OP_CCW: begin
                nx = clamp(round_q14(dx * c - dy * s), DIR_MIN, DIR_MAX);
                ny = clamp(round_q14(dy * c + dx * s), DIR_MIN, DIR_MAX);
                pose.dir_x = nx[15:0];
                pose.dir_y = ny[15:0];
            end
            OP_PUSH: begin
                if (saved_cnt >= DEPTH) begin
                    push_status(ST_OVERFLOW);
                end else begin
                    saved_poses[saved_cnt] = pose;
                    saved_cnt++;
                end
            end
            OP_POP: begin
                if (saved_cnt == 0) begin
                    push_status(ST_UNDERFLOW);
                end else begin
                    saved_cnt--;
                    pose = saved_poses[saved_cnt];
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_segs.size() == 0) begin
                mismatches++;
                $display("%0t: result expected none actual %h", $time, o_out);
            end else begin
                want = pending_segs.pop_front();
                check_field("seg_start_x", want.seg_start_x, o_out.seg_start_x);
                check_field("seg_start_y", want.seg_start_y, o_out.seg_start_y);
                check_field("seg_end_x", want.seg_end_x, o_out.seg_end_x);
                check_field("seg_end_y", want.seg_end_y, o_out.seg_end_y);
                check_field("status", want.status, o_out.status);
            end
        end
    end

    // result side: random back-pressure, long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    task automatic send_symbol(input logic [7:0] sym, input logic rst);
        int       gap;
        t_in_item req;
        gap = 0;
        req.symbol  = sym;
        req.restart = rst;
        while ($urandom_range(99) < in_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (!o_in_ready);
        predict_turtle(req);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_segs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [23:0] sx, input logic [23:0] sy,
                                 input logic [15:0] dx, input logic [15:0] dy,
                                 input logic [15:0] step, input logic [15:0] c,
                                 input logic [15:0] s);
        wait_idle();
        put_reg(CFG_START_X, sx);
        put_reg(CFG_START_Y, sy);
        put_reg(CFG_START_DX, {8'h00, dx});
        put_reg(CFG_START_DY, {8'h00, dy});
        put_reg(CFG_STEP_LEN, {8'h00, step});
        put_reg(CFG_COS_ANGLE, {8'h00, c});
        put_reg(CFG_SIN_ANGLE, {8'h00, s});
        i_cfg_we    <= 1'b0;
        cfg_start_x = sx;
        cfg_start_y = sy;
        cfg_dir_x   = dx;
        cfg_dir_y   = dy;
        cfg_step    = step;
        cfg_cos     = c;
        cfg_sin     = s;
        @(posedge i_clk);
    endtask

    // bracketed random walks, n_items symbols in all
    task automatic run_walks(input int n_items);
        int         sent, len, push_w, r;
        logic [7:0] sym;
        logic       rst;
        sent = 0;
        while (sent < n_items) begin
            len    = $urandom_range(60, 10);
            push_w = ($urandom_range(9) == 0) ? 45 : $urandom_range(25, 10);
            for (int k = 0; k < len && sent < n_items; k++) begin
                r   = $urandom_range(99);
                rst = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
                if (r < push_w)
                    sym = SYM_PUSH;
                else if (r < push_w + 12)
                    sym = SYM_POP;
                else if (r < push_w + 22)
                    sym = SYM_CW;
                else if (r < push_w + 32)
                    sym = SYM_CCW;
                else if (r < 93)
                    sym = SYM_FWD;
                else
                    sym = 8'($urandom_range(255));
                send_symbol(sym, rst);
                sent++;
            end
        end
    endtask

    task automatic test_directed_basic();
        send_symbol(SYM_FWD, 1'b0);
        send_symbol(SYM_CW, 1'b0);
        send_symbol(SYM_FWD, 1'b0);
        send_symbol(SYM_CCW, 1'b0);
        send_symbol(SYM_POP, 1'b0);
        send_symbol(SYM_PUSH, 1'b0);
        send_symbol(SYM_FWD, 1'b0);
        send_symbol(SYM_POP, 1'b0);
        send_symbol(8'h00, 1'b1);
        send_symbol(8'hFF, 1'b0);
        send_symbol(SYM_FWD, 1'b1);
    endtask

    task automatic test_stack_overflow();
        send_symbol(SYM_PUSH, 1'b1);
        for (int k = 1; k < DEPTH; k++)
            send_symbol(SYM_PUSH, 1'b0);
        send_symbol(SYM_PUSH, 1'b0);
        send_symbol(SYM_POP, 1'b0);
    endtask

    task automatic test_default_walks();
        run_walks(300);
    endtask

    task automatic test_back_to_back();
        wait_idle();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_walks(300);
        wait_idle();
        in_idle_pct  = 35;
        out_idle_pct = 35;
    endtask

    task automatic test_output_hold_off();
        wait_idle();
        in_idle_pct = 0;
        hold_req    = 1'b1;
        for (int k = 0; k < 80; k++)
            send_symbol(($urandom_range(3) == 0) ? SYM_CW : SYM_FWD, 1'b0);
        in_idle_pct = 35;
    endtask

    task automatic test_random_settings();
        logic [15:0] step;
        for (int p = 0; p < 4; p++) begin
            step = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                            : 16'($urandom_range(4095));
            load_settings(24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF)),
                          16'($urandom_range(32768) - 16384),
                          16'($urandom_range(32768) - 16384), step,
                          16'($urandom_range(32768) - 16384),
                          16'($urandom_range(32768) - 16384));
            send_symbol(SYM_FWD, 1'b0);
            run_walks(220);
        end
    endtask

    task automatic test_extreme_settings();
        load_settings(24'h7FFFFF, 24'h800000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd16384, 16'd0);
        run_walks(80);
        load_settings(24'h800000, 24'h7FFFFF, 16'h8000, 16'h7FFF, 16'hFFFF,
                      16'd16384, 16'd16384);
        run_walks(80);
        load_settings(24'h000000, 24'h000000, 16'h8000, 16'h8000, 16'h0000,
                      -16'sd16384, -16'sd16384);
        run_walks(80);
        // cosine and sine beyond unit range
        load_settings(24'h000100, 24'hFFFF00, 16'h7FFF, 16'h7FFF, 16'h0001,
                      16'h7FFF, 16'h8000);
        run_walks(80);
    endtask

    initial begin
        load_start_pose();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_basic();
        test_stack_overflow();
        test_default_walks();
        test_back_to_back();
        test_output_hold_off();
        test_random_settings();
        test_extreme_settings();
        wait_idle();
        if (mismatches == 0 && pending_segs.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
